// ===== rtl/pps_pkg.sv =====
// ----------------------------------------------------------------------------
// pps_pkg: shared types, constants and helpers of the particle step pipeline
// Q16.16 kinematics, Q1.16 factors, register map and saturation helpers.
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int Q_FRAC      = 16;
    localparam int NUM_STAGES  = 9;
    localparam int AXIS_STAGES = 7;

    typedef logic signed [31:0] q16_t;     // signed Q16.16
    typedef logic        [31:0] uq16_t;    // unsigned Q16.16
    typedef logic        [23:0] uq8_t;     // unsigned Q8.16 (time step, drag)
    typedef logic        [16:0] frac_t;    // unsigned Q1.16, 1.0 = 0x10000

    typedef logic signed [56:0] prod57_t;  // Q16.16 x Q8.16
    typedef logic signed [49:0] prod50_t;  // Q16.16 x Q1.16
    typedef logic signed [41:0] wide_t;    // rescaled sum before saturation

    localparam frac_t FRAC_ONE = 17'h10000;

    // register map
    typedef enum logic [2:0] {
        REG_GRAVITY_X  = 3'd0,
        REG_GRAVITY_Y  = 3'd1,
        REG_GRAVITY_Z  = 3'd2,
        REG_DRAG       = 3'd3,
        REG_DAMPING    = 3'd4,
        REG_GROUND_EN  = 3'd5,
        REG_BOUNCE     = 3'd6,
        REG_FRICTION   = 3'd7
    } cfg_reg_e;

    localparam q16_t  GRAVITY_X_RST = 32'sd0;
    localparam q16_t  GRAVITY_Y_RST = -32'sd642253;
    localparam q16_t  GRAVITY_Z_RST = 32'sd0;
    localparam uq8_t  DRAG_RST      = 24'd0;
    localparam frac_t DAMPING_RST   = 17'd65536;
    localparam logic  GROUND_EN_RST = 1'b0;
    localparam frac_t BOUNCE_RST    = 17'd32768;
    localparam frac_t FRICTION_RST  = 17'd6554;

    localparam uq16_t AGE_MAX = 32'hFFFF_FFFF;

    // position and velocity of one particle, index 0..2 = x, y, z
    typedef struct packed {
        q16_t [2:0] pos;
        q16_t [2:0] vel;
    } kin_t;

    // per-item sideband that rides beside the axis lanes
    typedef struct packed {
        logic  alive;
        uq16_t age;
        uq8_t  dt;
        kin_t  orig;
    } side_t;

    function automatic q16_t sat32(input wide_t x);
        q16_t r;
        if (x > 42'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < -42'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = q16_t'(x);
        end
        return r;
    endfunction

    function automatic frac_t clamp_one(input frac_t v);
        return (v > FRAC_ONE) ? FRAC_ONE : v;
    endfunction

endpackage

// ===== rtl/pps_axis.sv =====
// ----------------------------------------------------------------------------
// pps_axis: seven-stage velocity and position lane for one axis
// drag, gravity, velocity integrate, damping, position integrate.
// ----------------------------------------------------------------------------
module pps_axis (
    input  logic                                aclk,
    input  logic [pps_pkg::AXIS_STAGES-1:0]     stage_en,
    input  pps_pkg::q16_t                       pos_in,
    input  pps_pkg::q16_t                       vel_in,
    input  pps_pkg::q16_t                       grav,
    input  pps_pkg::uq8_t                       drag,
    input  pps_pkg::frac_t                      damp,
    input  pps_pkg::uq8_t                       dt_s2,   // time step of item in stage 1
    input  pps_pkg::uq8_t                       dt_s5,   // time step of item in stage 4
    output pps_pkg::q16_t                       pos_out,
    output pps_pkg::q16_t                       vel_out
);
    import pps_pkg::*;

    prod57_t p1_reg, p1_next;
    q16_t    vel0_reg, pos0_reg;
    q16_t    acc_reg, acc_next;
    q16_t    vel1_reg, pos1_reg;
    prod57_t p2_reg, p2_next;
    q16_t    vel2_reg, pos2_reg;
    q16_t    v1_reg, v1_next;
    q16_t    pos3_reg;
    prod50_t p3_reg, p3_next;
    q16_t    pos4_reg;
    q16_t    v2_reg, v2_next;
    prod57_t p4_reg, p4_next;
    q16_t    pos5_reg;
    q16_t    npos_reg, npos_next;
    q16_t    v2o_reg;

    always_comb begin
        p1_next   = prod57_t'(vel_in) * prod57_t'($signed({1'b0, drag}));
        acc_next  = sat32(wide_t'(grav) - wide_t'(p1_reg >>> Q_FRAC));
        p2_next   = prod57_t'(acc_reg) * prod57_t'($signed({1'b0, dt_s2}));
        v1_next   = sat32(wide_t'(vel2_reg) + wide_t'(p2_reg >>> Q_FRAC));
        p3_next   = prod50_t'(v1_reg) * prod50_t'($signed({1'b0, damp}));
        // damping never exceeds one, so the scaled velocity fits 32 bits
        v2_next   = q16_t'(p3_reg >>> Q_FRAC);
        p4_next   = prod57_t'(v2_next) * prod57_t'($signed({1'b0, dt_s5}));
        npos_next = sat32(wide_t'(pos5_reg) + wide_t'(p4_reg >>> Q_FRAC));
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            p1_reg   <= p1_next;
            vel0_reg <= vel_in;
            pos0_reg <= pos_in;
        end
        if (stage_en[1]) begin
            acc_reg  <= acc_next;
            vel1_reg <= vel0_reg;
            pos1_reg <= pos0_reg;
        end
        if (stage_en[2]) begin
            p2_reg   <= p2_next;
            vel2_reg <= vel1_reg;
            pos2_reg <= pos1_reg;
        end
        if (stage_en[3]) begin
            v1_reg   <= v1_next;
            pos3_reg <= pos2_reg;
        end
        if (stage_en[4]) begin
            p3_reg   <= p3_next;
            pos4_reg <= pos3_reg;
        end
        if (stage_en[5]) begin
            v2_reg   <= v2_next;
            p4_reg   <= p4_next;
            pos5_reg <= pos4_reg;
        end
        if (stage_en[6]) begin
            npos_reg <= npos_next;
            v2o_reg  <= v2_reg;
        end
    end

    assign pos_out = npos_reg;
    assign vel_out = v2o_reg;

endmodule

// ===== rtl/pps_ground.sv =====
// ----------------------------------------------------------------------------
// pps_ground: ground plane collision and result select, two stages
// Products for bounce and friction, then clamp, reflect and output register.
// ----------------------------------------------------------------------------
module pps_ground (
    input  logic                aclk,
    input  logic [1:0]          stage_en,
    input  logic                ground_en,
    input  pps_pkg::frac_t      bounce,     // clamped to one
    input  pps_pkg::frac_t      keep,       // one minus clamped friction
    input  pps_pkg::kin_t       kin_in,
    input  pps_pkg::side_t      side_in,
    output pps_pkg::kin_t       kin_out,
    output pps_pkg::uq16_t      age_out,
    output logic                alive_out
);
    import pps_pkg::*;

    logic    hit_reg, hit_next;
    kin_t    kin_reg;
    prod50_t pvx_reg, pvy_reg, pvz_reg;
    logic    alive_reg;
    uq16_t   age_reg;
    kin_t    orig_reg;

    kin_t    kin_out_reg, kin_out_next;
    uq16_t   age_out_reg;
    logic    alive_out_reg;

    prod50_t pvy_neg;

    assign hit_next = ground_en && ($signed(kin_in.pos[1]) <= 32'sd0);

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            hit_reg   <= hit_next;
            kin_reg   <= kin_in;
            pvx_reg   <= prod50_t'($signed(kin_in.vel[0])) * prod50_t'($signed({1'b0, keep}));
            pvy_reg   <= prod50_t'($signed(kin_in.vel[1])) * prod50_t'($signed({1'b0, bounce}));
            pvz_reg   <= prod50_t'($signed(kin_in.vel[2])) * prod50_t'($signed({1'b0, keep}));
            alive_reg <= side_in.alive;
            age_reg   <= side_in.age;
            orig_reg  <= side_in.orig;
        end
    end

    always_comb begin
        pvy_neg      = -pvy_reg;
        kin_out_next = kin_reg;
        if (hit_reg) begin
            kin_out_next.pos[1] = '0;
            kin_out_next.vel[1] = sat32(wide_t'(pvy_neg >>> Q_FRAC));
            kin_out_next.vel[0] = q16_t'(pvx_reg >>> Q_FRAC);
            kin_out_next.vel[2] = q16_t'(pvz_reg >>> Q_FRAC);
        end
        // inactive or dying particle keeps its entry kinematics
        if (!alive_reg) begin
            kin_out_next = orig_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            kin_out_reg   <= kin_out_next;
            age_out_reg   <= age_reg;
            alive_out_reg <= alive_reg;
        end
    end

    assign kin_out   = kin_out_reg;
    assign age_out   = age_out_reg;
    assign alive_out = alive_out_reg;

endmodule

// ===== rtl/particle_physics_step.sv =====
// ----------------------------------------------------------------------------
// particle_physics_step: one explicit Euler step per particle, fixed point
// Pipeline: 7 axis stages and 2 ground stages from input beat to result beat.
// Throughput: one beat per cycle; each stage holds only while the stage after
// it is full and blocked, so bubbles close up and nothing is lost or repeated.
// Reset (aresetn low, synchronous): all stage valid bits clear and the
// configuration registers return to their defaults.
// ----------------------------------------------------------------------------
module particle_physics_step (
    input  logic                aclk,
    input  logic                aresetn,

    // input particle stream
    input  logic                s_tvalid,
    output logic                s_tready,
    // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z, [127:96] vel_x,
    // [159:128] vel_y, [191:160] vel_z, [223:192] age, [255:224] life_span,
    // [279:256] time_step
    input  logic [279:0]        s_tdata,
    // [0] alive_in
    input  logic                s_tuser,

    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    // [31:0] new_pos_x, [63:32] new_pos_y, [95:64] new_pos_z,
    // [127:96] new_vel_x, [159:128] new_vel_y, [191:160] new_vel_z,
    // [223:192] new_age
    output logic [223:0]        m_tdata,
    // [0] alive_out
    output logic                m_tuser,

    // configuration write port
    input  logic                cfg_wr_en,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_wdata
);
    import pps_pkg::*;

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    q16_t  grav_reg [3];
    uq8_t  drag_reg;
    frac_t damping_reg;
    logic  ground_en_reg;
    frac_t bounce_reg;
    frac_t friction_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grav_reg[0]   <= GRAVITY_X_RST;
            grav_reg[1]   <= GRAVITY_Y_RST;
            grav_reg[2]   <= GRAVITY_Z_RST;
            drag_reg      <= DRAG_RST;
            damping_reg   <= DAMPING_RST;
            ground_en_reg <= GROUND_EN_RST;
            bounce_reg    <= BOUNCE_RST;
            friction_reg  <= FRICTION_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_e'(cfg_index))
                REG_GRAVITY_X: grav_reg[0]   <= cfg_wdata;
                REG_GRAVITY_Y: grav_reg[1]   <= cfg_wdata;
                REG_GRAVITY_Z: grav_reg[2]   <= cfg_wdata;
                REG_DRAG:      drag_reg      <= cfg_wdata[23:0];
                REG_DAMPING:   damping_reg   <= cfg_wdata[16:0];
                REG_GROUND_EN: ground_en_reg <= cfg_wdata[0];
                REG_BOUNCE:    bounce_reg    <= cfg_wdata[16:0];
                REG_FRICTION:  friction_reg  <= cfg_wdata[16:0];
            endcase
        end
    end

    // factors above one act as one
    frac_t damp_eff, bounce_eff, keep_eff;
    assign damp_eff   = clamp_one(damping_reg);
    assign bounce_eff = clamp_one(bounce_reg);
    assign keep_eff   = FRAC_ONE - clamp_one(friction_reg);

    // ---------------------------------------------------------------------
    // Stage control: valid bit per stage, ready ripples back from the
    // output register so a stage loads whenever it is empty or drains.
    // ---------------------------------------------------------------------
    logic [NUM_STAGES-1:0] valid_reg, valid_next;
    logic [NUM_STAGES-1:0] stage_ready;

    always_comb begin
        stage_ready[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
        valid_next[0] = s_tvalid;
        for (int k = 1; k < NUM_STAGES; k++) begin
            valid_next[k] = valid_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int k = 0; k < NUM_STAGES; k++) begin
                if (stage_ready[k]) begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    assign s_tready = stage_ready[0];
    assign m_tvalid = valid_reg[NUM_STAGES-1];

    // ---------------------------------------------------------------------
    // Entry: unpack the beat, age the particle and decide whether it lives
    // ---------------------------------------------------------------------
    kin_t     kin_in;
    uq16_t    age_in, span_in;
    uq8_t     dt_in;
    logic [32:0] age_sum;
    uq16_t    aged;
    side_t    side_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            kin_in.pos[i] = s_tdata[32*i +: 32];
            kin_in.vel[i] = s_tdata[96 + 32*i +: 32];
        end
        age_in  = s_tdata[223:192];
        span_in = s_tdata[255:224];
        dt_in   = s_tdata[279:256];

        age_sum = {1'b0, age_in} + 33'(dt_in);
        aged    = age_sum[32] ? AGE_MAX : age_sum[31:0];

        side_next.dt   = dt_in;
        side_next.orig = kin_in;
        if (s_tuser) begin
            side_next.age   = aged;
            side_next.alive = (aged < span_in);   // dies once age reaches span
        end else begin
            side_next.age   = age_in;
            side_next.alive = 1'b0;
        end
    end

    // sideband shift line beside the axis lanes, stages 0..6
    side_t side_reg [AXIS_STAGES];

    always_ff @(posedge aclk) begin
        if (stage_ready[0]) begin
            side_reg[0] <= side_next;
        end
        for (int k = 1; k < AXIS_STAGES; k++) begin
            if (stage_ready[k]) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // ---------------------------------------------------------------------
    // Axis lanes
    // ---------------------------------------------------------------------
    kin_t lane_kin;

    for (genvar i = 0; i < 3; i++) begin : g_axis
        pps_axis u_axis (
            .aclk     (aclk),
            .stage_en (stage_ready[AXIS_STAGES-1:0]),
            .pos_in   (kin_in.pos[i]),
            .vel_in   (kin_in.vel[i]),
            .grav     (grav_reg[i]),
            .drag     (drag_reg),
            .damp     (damp_eff),
            .dt_s2    (side_reg[1].dt),
            .dt_s5    (side_reg[4].dt),
            .pos_out  (lane_kin.pos[i]),
            .vel_out  (lane_kin.vel[i])
        );
    end

    // ---------------------------------------------------------------------
    // Ground plane and output register
    // ---------------------------------------------------------------------
    kin_t  kin_out;
    uq16_t age_out;
    logic  alive_out;

    pps_ground u_ground (
        .aclk      (aclk),
        .stage_en  (stage_ready[NUM_STAGES-1:AXIS_STAGES]),
        .ground_en (ground_en_reg),
        .bounce    (bounce_eff),
        .keep      (keep_eff),
        .kin_in    (lane_kin),
        .side_in   (side_reg[AXIS_STAGES-1]),
        .kin_out   (kin_out),
        .age_out   (age_out),
        .alive_out (alive_out)
    );

    assign m_tdata = {age_out,
                      kin_out.vel[2], kin_out.vel[1], kin_out.vel[0],
                      kin_out.pos[2], kin_out.pos[1], kin_out.pos[0]};
    assign m_tuser = alive_out;

endmodule

// ===== rtl/pps_checker.sv =====
// ----------------------------------------------------------------------------
// pps_checker: port-level checks for the particle step block
// Output hold under stall, reset, ready behavior and the life invariant.
// ----------------------------------------------------------------------------
module pps_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [223:0] m_tdata,
    input logic         m_tuser
);

    // a stalled result beat holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // an empty or draining output never blocks the input side
    a_ready_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input blocked while output drains");

    // a living particle has age strictly below its span, so never the ceiling
    a_alive_age: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[223:192] != 32'hFFFF_FFFF)
        else $error("alive particle with saturated age");

endmodule

bind particle_physics_step pps_checker u_pps_checker (.*);
